// ===== hw/rtl/ttss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttss_pkg
// Shared types and constants for the timer slot scheduler.
// ----------------------------------------------------------------------------
package ttss_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int TIME_W = 48;
  localparam int SEQ_W = 32;
  localparam int DLY_W = 24;

  typedef enum logic [1:0] {
    MODE_ADD_ONCE = 2'd0,
    MODE_ADD_REP  = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_TICK     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_REMOVED  = 3'd2,
    KIND_NOTFOUND = 3'd3,
    KIND_FIRED    = 3'd4,
    KIND_IDLE     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_FIRE_RD,
    ST_FIRE_WR,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/timed_task_slot_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_task_slot_scheduler_core
// Timer slot table with one-shot and periodic slots.
// ----------------------------------------------------------------------------
// Usage: drive mode/delay/period/handle with start high while busy is low.
// Add and remove items give one result in the cycle after they are accepted
// (busy is high while it shows). A tick item scans the usable slots
// (U = min(SLOTS,16)) through the deadline/sequence memory, one read per
// cycle, to find the earliest due slot, then fires it with a read and a
// write-back. Each fired slot takes a scan pass, the wait state and the
// fire states FIRE_RD and FIRE_WR; a closing pass finds nothing more.
// A tick keeps busy high through its closing pass; an idle tick then gives
// one KIND_IDLE result. Every result appears on kind/slot/repeats/
// last for exactly one cycle with strobe high; last marks the final result
// of an item. The receiver cannot stall: results are never held.
// Reset clears the valid and repeat flags, the time and the sequence count;
// slot memories are not cleared and their contents are used only for
// valid slots.
// ----------------------------------------------------------------------------
module timed_task_slot_scheduler_core #(
  parameter int SLOTS = ttss_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [23:0] delay,
  input  logic [23:0] period,
  input  logic [3:0]  handle,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic        repeats,
  output logic        last
);

  localparam int USABLE = (SLOTS < 16) ? SLOTS : 16;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UW = $clog2(USABLE + 1);
  localparam int TW = ttss_pkg::TIME_W;
  localparam int SW = ttss_pkg::SEQ_W;
  localparam int DW = ttss_pkg::DLY_W;

  // key memory: deadline + sequence; period memory separate
  logic [TW+SW-1:0] key_mem [SLOTS];
  logic [DW-1:0]    per_mem [SLOTS];
  logic [TW+SW-1:0] key_rd;
  logic [DW-1:0]    per_rd;
  logic             key_we;
  logic [IW-1:0]    key_wa, key_ra;
  logic [TW+SW-1:0] key_wd;
  logic             per_we;
  logic [DW-1:0]    per_wd;

  logic [SLOTS-1:0] valid, rep, due;
  logic [TW-1:0]    now;
  logic [SW-1:0]    seq;

  ttss_pkg::state_t state, state_next;
  logic [UW-1:0]    idx;
  logic [IW-1:0]    rd_idx;
  logic             have_best, fired_any;
  logic [IW-1:0]    best;
  logic [TW+SW-1:0] best_key;

  logic             accept;
  logic [IW-1:0]    free_idx;
  logic             free_found;
  logic             hnd_ok;

  assign accept = start && !busy;
  assign busy = (state != ttss_pkg::ST_IDLE) || strobe;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign hnd_ok = (32'(handle) < USABLE) && valid[IW'(handle)];

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (per_we) per_mem[key_wa] <= per_wd;
    key_rd <= key_mem[key_ra];
    per_rd <= per_mem[key_ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      ttss_pkg::ST_IDLE:
        if (accept && mode == ttss_pkg::MODE_TICK) state_next = ttss_pkg::ST_SCAN;
      ttss_pkg::ST_SCAN:
        if (idx == UW'(USABLE)) state_next = ttss_pkg::ST_SCAN_WAIT;
      ttss_pkg::ST_SCAN_WAIT:
        state_next = have_best ? ttss_pkg::ST_FIRE_RD : ttss_pkg::ST_DONE;
      ttss_pkg::ST_FIRE_RD: state_next = ttss_pkg::ST_FIRE_WR;
      ttss_pkg::ST_FIRE_WR: state_next = ttss_pkg::ST_SCAN;
      ttss_pkg::ST_DONE:    state_next = ttss_pkg::ST_IDLE;
      default:              state_next = ttss_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    key_ra = IW'(idx);
    if (state == ttss_pkg::ST_FIRE_RD) key_ra = best;
    key_we = 1'b0;
    per_we = 1'b0;
    key_wa = best;
    key_wd = {now + TW'(per_rd), seq};
    per_wd = period;
    if (state == ttss_pkg::ST_IDLE && accept && !mode[1] && free_found) begin
      key_we = 1'b1;
      per_we = 1'b1;
      key_wa = free_idx;
      key_wd = {now + TW'(delay), seq};
    end else if (state == ttss_pkg::ST_FIRE_WR && rep[best]) begin
      key_we = 1'b1;
    end
  end

  // a slot read in the previous cycle is compared here
  logic              cmp_ok;
  logic              cmp_less;
  always_comb begin
    cmp_ok = (state == ttss_pkg::ST_SCAN) && idx != '0 && due[rd_idx];
    cmp_less = !have_best || (key_rd < best_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttss_pkg::ST_IDLE;
      valid <= '0;
      rep <= '0;
      due <= '0;
      now <= '0;
      seq <= '0;
      strobe <= 1'b0;
      idx <= '0;
      have_best <= 1'b0;
      fired_any <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= (state == ttss_pkg::ST_IDLE && accept && mode != ttss_pkg::MODE_TICK)
                || (state == ttss_pkg::ST_FIRE_WR)
                || (state == ttss_pkg::ST_DONE && !fired_any);
      case (state)
        ttss_pkg::ST_IDLE: begin
          idx <= '0;
          have_best <= 1'b0;
          fired_any <= 1'b0;
          if (accept) begin
            case (mode)
              ttss_pkg::MODE_ADD_ONCE, ttss_pkg::MODE_ADD_REP: begin
                last <= 1'b1;
                repeats <= 1'b0;
                if (free_found) begin
                  valid[free_idx] <= 1'b1;
                  rep[free_idx] <= mode[0];
                  seq <= seq + 1'b1;
                  kind <= ttss_pkg::KIND_ADDED;
                  slot <= 4'(free_idx);
                end else begin
                  kind <= ttss_pkg::KIND_FULL;
                  slot <= '0;
                end
              end
              ttss_pkg::MODE_REMOVE: begin
                last <= 1'b1;
                repeats <= 1'b0;
                slot <= handle;
                if (hnd_ok) begin
                  valid[IW'(handle)] <= 1'b0;
                  rep[IW'(handle)] <= 1'b0;
                  kind <= ttss_pkg::KIND_REMOVED;
                end else begin
                  kind <= ttss_pkg::KIND_NOTFOUND;
                end
              end
              default: begin
                now <= now + 1'b1;
                due <= valid;  // refined by deadline during first scan
              end
            endcase
          end
        end
        ttss_pkg::ST_SCAN, ttss_pkg::ST_SCAN_WAIT: begin
          if (state == ttss_pkg::ST_SCAN) begin
            rd_idx <= IW'(idx);
            if (idx != UW'(USABLE)) idx <= idx + 1'b1;
          end
          if (cmp_ok) begin
            if (fired_any == 1'b0 && key_rd[TW+SW-1:SW] > now) begin
              due[rd_idx] <= 1'b0;
            end else if (cmp_less) begin
              have_best <= 1'b1;
              best <= rd_idx;
              best_key <= key_rd;
            end
          end
        end
        ttss_pkg::ST_FIRE_RD: ;
        ttss_pkg::ST_FIRE_WR: begin
          kind <= ttss_pkg::KIND_FIRED;
          slot <= 4'(best);
          repeats <= rep[best];
          // last fired result: no due slot remains after the write-back
          last <= ((due & ~(SLOTS'(1) << best)) == '0);
          due[best] <= 1'b0;
          fired_any <= 1'b1;
          if (rep[best]) seq <= seq + 1'b1;
          else valid[best] <= 1'b0;
          idx <= '0;
          have_best <= 1'b0;
        end
        ttss_pkg::ST_DONE: begin
          if (!fired_any) begin
            kind <= ttss_pkg::KIND_IDLE;
            slot <= '0;
            repeats <= 1'b0;
            last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result without busy");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (state != ttss_pkg::ST_IDLE) |-> !accept) else $error("item taken while working");
  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ttss_pkg::ST_FIRE_WR) |-> valid[best]) else $error("fired free slot");
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == ttss_pkg::KIND_IDLE) |-> last) else $error("idle not last");
`endif

endmodule
